FILE: src/ptswt_pkg.sv
// Package for the peak-train step and walk-time unit.
// Shared widths, register indexes, controller state and command types.
// No dependencies.
`default_nettype none

package ptswt_pkg;

    localparam int PEAK_LIMIT = 512;

    localparam int IDX_W    = 32;                      // peak sample index
    localparam int CFG_W    = 16;                      // each config register
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W    = $clog2(PEAK_LIMIT + 1);  // kept / taken / gated counts
    localparam int STEPS_W  = 10;                      // merged step result field
    localparam int SUM_W    = $clog2(PEAK_LIMIT) + CFG_W; // sum of gaps, each <= gap_cap
    localparam int SCALE_SH = 8;
    localparam int DIV_W    = SUM_W + SCALE_SH + 1;    // scaled sum plus its mean
    localparam int TIME_W   = 40;

    localparam logic [CFG_IDX_W-1:0] REG_MERGE_GAP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_CAP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd2;

    localparam logic [CFG_W-1:0] MERGE_GAP_RST   = 16'd25;
    localparam logic [CFG_W-1:0] GAP_CAP_RST     = 16'd200;
    localparam logic [CFG_W-1:0] SAMPLE_RATE_RST = 16'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_RATE_START,
        ST_RATE_WAIT,
        ST_PUSH
    } ctrl_state_t;

    typedef struct packed {
        logic take_item;     // accept input item into session state
        logic div_start;     // launch shared divider
        logic div_sel_rate;  // 0: scaled sum / count, 1: total / sample rate
        logic load_mean;     // capture scaled sum plus mean
        logic load_time;     // capture walking time
        logic load_out;      // load result register, clear session
    } ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: src/ptswt_in_if.sv
// Input item channel for the peak-train unit.
// Depends on ptswt_pkg.
`default_nettype none

interface ptswt_in_if;
    logic                           valid;
    logic                           ready;
    logic [ptswt_pkg::IDX_W-1:0]    peak_index;
    logic                           has_peak;
    logic                           is_last;

    modport source (output valid, output peak_index, output has_peak, output is_last,
                    input ready);
    modport sink   (input valid, input peak_index, input has_peak, input is_last,
                    output ready);
endinterface

`default_nettype wire

FILE: src/ptswt_out_if.sv
// Result item channel for the peak-train unit.
// Depends on ptswt_pkg.
`default_nettype none

interface ptswt_out_if;
    logic                           valid;
    logic                           ready;
    logic [ptswt_pkg::STEPS_W-1:0]  merged_steps;
    logic [ptswt_pkg::TIME_W-1:0]   walk_time_q8;
    logic                           walk_time_valid;

    modport source (output valid, output merged_steps, output walk_time_q8,
                    output walk_time_valid, input ready);
    modport sink   (input valid, input merged_steps, input walk_time_q8,
                    input walk_time_valid, output ready);
endinterface

`default_nettype wire

FILE: src/ptswt_cfg_if.sv
// Configuration write channel for the peak-train unit.
// Depends on ptswt_pkg.
`default_nettype none

interface ptswt_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ptswt_pkg::CFG_IDX_W-1:0]    index;
    logic [ptswt_pkg::CFG_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/ptswt_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ptswt_pkg for operand widths.
`default_nettype none

module ptswt_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ptswt_pkg::DIV_W-1:0] dividend,
    input  wire logic [ptswt_pkg::CFG_W-1:0] divisor,
    output logic                             done,
    output logic [ptswt_pkg::DIV_W-1:0]      quotient
);
    import ptswt_pkg::*;

    localparam int STEP_W = $clog2(DIV_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CFG_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [CFG_W-1:0]  dvs_reg, dvs_next;
    logic [CFG_W:0]    partial;
    logic [CFG_W+1:0]  diff;

    always_comb
    begin
        partial   = {rem_reg, quo_reg[DIV_W-1]};
        diff      = {1'b0, partial} - {2'b00, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // borrow set means the trial subtract failed: keep the partial remainder
            rem_next = diff[CFG_W+1] ? partial[CFG_W-1:0] : diff[CFG_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ~diff[CFG_W+1]};
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: src/ptswt_ctrl.sv
// Controller for the peak-train unit: item handshake, divide sequence, result slot.
// Depends on ptswt_pkg.
`default_nettype none

module ptswt_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_last,
    input  wire logic                  out_ready,
    input  wire logic                  div_done,
    output logic                       in_ready,
    output logic                       out_valid,
    output ptswt_pkg::ctrl_cmd_t       cmd
);
    import ptswt_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && in_last)
                    state_next = ST_MEAN_START;
            ST_MEAN_START:
                state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT:
                if (div_done)
                    state_next = ST_RATE_START;
            ST_RATE_START:
                state_next = ST_RATE_WAIT;
            ST_RATE_WAIT:
                if (div_done)
                    state_next = ST_PUSH;
            ST_PUSH:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_item = in_valid;
            end
            ST_MEAN_START:
                cmd.div_start = 1'b1;
            ST_MEAN_WAIT:
                cmd.load_mean = div_done;
            ST_RATE_START:
            begin
                cmd.div_start    = 1'b1;
                cmd.div_sel_rate = 1'b1;
            end
            ST_RATE_WAIT:
                cmd.load_time = div_done;
            ST_PUSH:
                cmd.load_out = slot_free;
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/ptswt_dp.sv
// Datapath for the peak-train unit: config registers, session accumulators,
// divider operand selection and the result register. Depends on ptswt_pkg.
`default_nettype none

module ptswt_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ptswt_pkg::ctrl_cmd_t          cmd,
    input  wire logic                          cfg_we,
    input  wire logic [ptswt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ptswt_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic [ptswt_pkg::IDX_W-1:0]   peak_index,
    input  wire logic                          has_peak,
    input  wire logic [ptswt_pkg::DIV_W-1:0]   div_quotient,
    output logic [ptswt_pkg::DIV_W-1:0]        div_dividend,
    output logic [ptswt_pkg::CFG_W-1:0]        div_divisor,
    output logic [ptswt_pkg::STEPS_W-1:0]      merged_steps,
    output logic [ptswt_pkg::TIME_W-1:0]       walk_time_q8,
    output logic                               walk_time_valid
);
    import ptswt_pkg::*;

    logic [CFG_W-1:0] merge_gap_reg, gap_cap_reg, rate_reg;

    logic             seen_first_reg, seen_first_next;
    logic [IDX_W-1:0] last_kept_reg, last_kept_next;
    logic [IDX_W-1:0] prev_reg, prev_next;
    logic [CNT_W-1:0] kept_reg, kept_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] gated_reg, gated_next;
    logic [CNT_W-1:0] taken_reg, taken_next;

    logic [DIV_W-1:0] total_reg;     // scaled sum plus mean
    logic [DIV_W-1:0] time_reg;

    logic [STEPS_W-1:0] steps_out_reg;
    logic [TIME_W-1:0]  time_out_reg;
    logic               tvalid_out_reg;

    logic [IDX_W-1:0] gap, kept_dist;
    logic [DIV_W-1:0] scaled;
    logic             take;
    logic             time_ok;
    logic [DIV_W+TIME_W-1:0] time_wide;
    logic [TIME_W-1:0]       time_sat;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_gap_reg <= MERGE_GAP_RST;
            gap_cap_reg   <= GAP_CAP_RST;
            rate_reg      <= SAMPLE_RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MERGE_GAP:   merge_gap_reg <= cfg_data;
                REG_GAP_CAP:     gap_cap_reg   <= cfg_data;
                REG_SAMPLE_RATE: rate_reg      <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign gap       = peak_index - prev_reg;
    assign kept_dist = peak_index - last_kept_reg;
    assign take      = cmd.take_item && has_peak && (taken_reg < CNT_W'(PEAK_LIMIT));

    always_comb
    begin
        seen_first_next = seen_first_reg;
        last_kept_next  = last_kept_reg;
        prev_next       = prev_reg;
        kept_next       = kept_reg;
        sum_next        = sum_reg;
        gated_next      = gated_reg;
        taken_next      = taken_reg;
        if (cmd.load_out)
        begin
            seen_first_next = 1'b0;
            last_kept_next  = '0;
            prev_next       = '0;
            kept_next       = '0;
            sum_next        = '0;
            gated_next      = '0;
            taken_next      = '0;
        end
        else if (take)
        begin
            if (!seen_first_reg)
            begin
                seen_first_next = 1'b1;
                kept_next       = CNT_W'(1);
                last_kept_next  = peak_index;
            end
            else
            begin
                if (gap <= {{(IDX_W-CFG_W){1'b0}}, gap_cap_reg})
                begin
                    sum_next   = sum_reg + SUM_W'(gap[CFG_W-1:0]);
                    gated_next = gated_reg + 1'b1;
                end
                if (kept_dist >= {{(IDX_W-CFG_W){1'b0}}, merge_gap_reg})
                begin
                    kept_next      = kept_reg + 1'b1;
                    last_kept_next = peak_index;
                end
            end
            prev_next  = peak_index;
            taken_next = taken_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_first_reg <= 1'b0;
            last_kept_reg  <= '0;
            prev_reg       <= '0;
            kept_reg       <= '0;
            sum_reg        <= '0;
            gated_reg      <= '0;
            taken_reg      <= '0;
        end
        else
        begin
            seen_first_reg <= seen_first_next;
            last_kept_reg  <= last_kept_next;
            prev_reg       <= prev_next;
            kept_reg       <= kept_next;
            sum_reg        <= sum_next;
            gated_reg      <= gated_next;
            taken_reg      <= taken_next;
        end
    end

    // divider operands; a zero rate divides by one
    // gated count stays below PEAK_LIMIT, so it fits the divisor width
    assign scaled = {1'b0, sum_reg, {SCALE_SH{1'b0}}};
    always_comb
    begin
        if (cmd.div_sel_rate)
        begin
            div_dividend = total_reg;
            div_divisor  = (rate_reg == '0) ? CFG_W'(1) : rate_reg;
        end
        else
        begin
            div_dividend = scaled;
            div_divisor  = CFG_W'(gated_reg);
        end
    end

    // mean <= scaled sum, so the total fits DIV_W bits when the count is nonzero
    always_ff @(posedge clk)
    begin
        if (cmd.load_mean)
            total_reg <= scaled + div_quotient;
        if (cmd.load_time)
            time_reg <= div_quotient;
    end

    // clamp to the 40-bit ceiling
    assign time_wide = {{TIME_W{1'b0}}, time_reg};
    assign time_sat  = (time_wide > {{DIV_W{1'b0}}, {TIME_W{1'b1}}}) ? '1
                                                                     : time_wide[TIME_W-1:0];
    assign time_ok   = (taken_reg >= CNT_W'(2)) && (gated_reg != '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            steps_out_reg  <= STEPS_W'(kept_reg);
            time_out_reg   <= time_ok ? time_sat : '0;
            tvalid_out_reg <= time_ok;
        end
    end

    assign merged_steps    = steps_out_reg;
    assign walk_time_q8    = time_out_reg;
    assign walk_time_valid = tvalid_out_reg;

endmodule

`default_nettype wire

FILE: src/peak_train_step_and_walk_time_unit.sv
// Top level of the peak-train step counter and walking-time estimator.
// Depends on ptswt_pkg, the three channel interfaces, ptswt_ctrl, ptswt_dp, ptswt_div.
//
//   channel  | dir | payload                                        | accept
//   ---------+-----+------------------------------------------------+------------------
//   cfg      | in  | index[1:0], data[15:0]                         | valid & ready
//   peaks    | in  | peak_index[31:0], has_peak, is_last            | valid & ready
//   result   | out | merged_steps[9:0], walk_time_q8[39:0], valid   | valid & ready
//
// A peak item is taken while the controller is idle. A closing item then runs two
// passes of the shared bit-serial divider (DIV_W = 34), and the result is loaded once
// the second pass is done, later while an older result still waits; peaks.ready is
// low after the closing item until that load.
// The result register lets new items in while a result waits for result.ready.
// Reset restores the register defaults and clears the session; cfg.ready is always high.
`default_nettype none

module peak_train_step_and_walk_time_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ptswt_cfg_if.sink  cfg,
    ptswt_in_if.sink   peaks,
    ptswt_out_if.source result
);
    import ptswt_pkg::*;

    ctrl_cmd_t        cmd;
    logic             div_done;
    logic [DIV_W-1:0] div_dividend;
    logic [CFG_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quotient;

    assign cfg.ready = 1'b1;

    ptswt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (peaks.valid),
        .in_last   (peaks.is_last),
        .out_ready (result.ready),
        .div_done  (div_done),
        .in_ready  (peaks.ready),
        .out_valid (result.valid),
        .cmd       (cmd)
    );

    ptswt_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .peak_index      (peaks.peak_index),
        .has_peak        (peaks.has_peak),
        .div_quotient    (div_quotient),
        .div_dividend    (div_dividend),
        .div_divisor     (div_divisor),
        .merged_steps    (result.merged_steps),
        .walk_time_q8    (result.walk_time_q8),
        .walk_time_valid (result.walk_time_valid)
    );

    ptswt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

`ifndef ASSERT_OFF
    a_no_div_while_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !peaks.ready)
        else $error("divider launched while items are accepted");

    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.load_out))
        else $error("result valid without a result load");

    a_time_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.walk_time_valid) |-> (result.walk_time_q8 == '0))
        else $error("nonzero walking time flagged invalid");
`endif

endmodule

`default_nettype wire
